FILE: rtl/plsc_pkg.sv
// ----------------------------------------------------------------------------
// plsc_pkg
// Shared types, constants and update functions for the path lexical check.
// ----------------------------------------------------------------------------
package plsc_pkg;

    localparam int unsigned COUNT_W = 11;
    localparam int unsigned TOTAL_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 11'd1025;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = 7'd127;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_HIGH      = 8'h80;

    typedef enum logic [1:0] {
        MODE_RELATIVE = 2'd0,
        MODE_ABSOLUTE = 2'd1,
        MODE_LEAF     = 2'd2,
        MODE_UNUSED   = 2'd3
    } path_mode_t;

    typedef enum logic [1:0] {
        DOT_NONE  = 2'd0,
        DOT_ONE   = 2'd1,
        DOT_TWO   = 2'd2,
        DOT_OTHER = 2'd3
    } dot_pattern_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       last_byte;
        logic       empty_path;
    } in_item_t;

    typedef struct packed {
        logic               path_safe;
        logic [COUNT_W-1:0] path_length;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [COUNT_W-1:0] component_length;
        logic [TOTAL_W-1:0] component_total;
        dot_pattern_t       dot_pattern;
        logic               rejected;
        logic               previous_was_slash;
    } path_state_t;

    localparam path_state_t STATE_CLEAR = '{
        byte_count:         '0,
        component_length:   '0,
        component_total:    '0,
        dot_pattern:        DOT_NONE,
        rejected:           1'b0,
        previous_was_slash: 1'b0
    };

    function automatic logic is_dot(input dot_pattern_t d);
        return (d == DOT_ONE) || (d == DOT_TWO);
    endfunction

    function automatic path_state_t add_byte(input path_state_t s, input logic [7:0] b);
        path_state_t r;
        r = s;
        if (s.component_length == '0)
        begin
            r.dot_pattern = (b == CHAR_DOT) ? DOT_ONE : DOT_OTHER;
        end
        else if (s.dot_pattern == DOT_ONE && b == CHAR_DOT)
        begin
            r.dot_pattern = DOT_TWO;
        end
        else
        begin
            r.dot_pattern = DOT_OTHER;
        end
        if (s.component_length < COUNT_SAT)
        begin
            r.component_length = s.component_length + 11'd1;
        end
        r.previous_was_slash = 1'b0;
        return r;
    endfunction

    function automatic path_state_t close_component(
        input path_state_t        s,
        input logic [COUNT_W-1:0] max_comp_bytes,
        input logic [TOTAL_W-1:0] max_comps
    );
        path_state_t r;
        r = s;
        if (s.component_length == '0 || s.component_length > max_comp_bytes ||
            is_dot(s.dot_pattern) || s.component_total >= max_comps)
        begin
            r.rejected = 1'b1;
        end
        if (s.component_total < TOTAL_SAT)
        begin
            r.component_total = s.component_total + 7'd1;
        end
        r.component_length = '0;
        r.dot_pattern      = DOT_NONE;
        return r;
    endfunction

endpackage

FILE: rtl/plsc_if.sv
// ----------------------------------------------------------------------------
// plsc_in_if / plsc_out_if
// Valid/ready channels for path bytes and for path verdicts.
// ----------------------------------------------------------------------------
interface plsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       last_byte;
    logic       empty_path;

    modport source (output valid, output path_byte, output last_byte,
                    output empty_path, input ready);
    modport sink   (input valid, input path_byte, input last_byte,
                    input empty_path, output ready);
endinterface

interface plsc_out_if;
    logic        valid;
    logic        ready;
    logic        path_safe;
    logic [10:0] path_length;

    modport source (output valid, output path_safe, output path_length, input ready);
    modport sink   (input valid, input path_safe, input path_length, output ready);
endinterface

FILE: rtl/path_lexical_safety_check.sv
// ----------------------------------------------------------------------------
// path_lexical_safety_check
// Streaming lexical check of a relative, root or leaf path.
// ----------------------------------------------------------------------------
// The bytes channel carries one path byte per item, with last_byte on the
// final byte; an item with empty_path set carries no byte and ends the path
// at once with path_safe low. The verdict channel gives one item per path:
// path_safe and the byte count, saturating at 1025.
// path_mode is written through path_mode_we / path_mode_wdata between paths.
// Each byte is held in the input register and is folded into the path
// counters and flags as it leaves; the verdict of a path is formed as its
// last item leaves. Barring a stall, one byte is taken every cycle.
// When the receiver stalls, the verdict stays in the result register and
// one more item is held in the input register; bytes that end no path still
// move on, and bytes stop being taken only when a second verdict waits.
// Reset clears all path state, selects relative mode and empties both
// registers.
// ----------------------------------------------------------------------------
module path_lexical_safety_check #(
    parameter int unsigned MAX_COMPONENT_BYTES = 255,
    parameter int unsigned MAX_COMPONENTS      = 64,
    parameter int unsigned MAX_PATH_BYTES      = 1024,
    parameter int unsigned MAX_LEAF_BYTES      = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       path_mode_we,
    input  logic [1:0] path_mode_wdata,
    plsc_in_if.sink    bytes,
    plsc_out_if.source verdict
);
    import plsc_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     advance;
    logic     out_space;
    logic     result_load;
    result_t  result;

    plsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    plsc_step #(
        .MAX_COMPONENT_BYTES (MAX_COMPONENT_BYTES),
        .MAX_COMPONENTS      (MAX_COMPONENTS),
        .MAX_PATH_BYTES      (MAX_PATH_BYTES),
        .MAX_LEAF_BYTES      (MAX_LEAF_BYTES)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_we     (path_mode_we),
        .mode_wdata  (path_mode_wdata),
        .item_valid  (item_valid),
        .item        (item),
        .out_space   (out_space),
        .advance     (advance),
        .result_load (result_load),
        .result      (result)
    );

    plsc_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (result_load),
        .result  (result),
        .space   (out_space),
        .verdict (verdict)
    );
endmodule

FILE: rtl/plsc_in_stage.sv
// ----------------------------------------------------------------------------
// plsc_in_stage
// Input register for one path byte item.
// ----------------------------------------------------------------------------
module plsc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    plsc_in_if.sink            bytes,
    input  logic               advance,
    output logic               item_valid,
    output plsc_pkg::in_item_t item
);
    import plsc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register refills in the same cycle that its item moves on.
    assign bytes.ready = !valid_reg || advance;
    assign valid_next  = bytes.valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            item_reg <= '{path_byte:  bytes.path_byte,
                          last_byte:  bytes.last_byte,
                          empty_path: bytes.empty_path};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

FILE: rtl/plsc_step.sv
// ----------------------------------------------------------------------------
// plsc_step
// Path state registers and the per-byte rule update, plus the mode register.
// ----------------------------------------------------------------------------
module plsc_step #(
    parameter int unsigned MAX_COMPONENT_BYTES = 255,
    parameter int unsigned MAX_COMPONENTS      = 64,
    parameter int unsigned MAX_PATH_BYTES      = 1024,
    parameter int unsigned MAX_LEAF_BYTES      = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mode_we,
    input  logic [1:0]          mode_wdata,
    input  logic                item_valid,
    input  plsc_pkg::in_item_t  item,
    input  logic                out_space,
    output logic                advance,
    output logic                result_load,
    output plsc_pkg::result_t   result
);
    import plsc_pkg::*;

    localparam logic [COUNT_W-1:0] MaxCompBytes = COUNT_W'(MAX_COMPONENT_BYTES);
    localparam logic [TOTAL_W-1:0] MaxComps     = TOTAL_W'(MAX_COMPONENTS);
    localparam logic [COUNT_W-1:0] MaxPath      = COUNT_W'(MAX_PATH_BYTES);
    localparam logic [COUNT_W-1:0] MaxLeaf      = COUNT_W'(MAX_LEAF_BYTES);

    path_mode_t  mode_reg;
    path_state_t state_reg;
    path_state_t state_next;
    path_state_t upd;
    logic        finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RELATIVE;
        end
        else if (mode_we)
        begin
            mode_reg <= path_mode_t'(mode_wdata);
        end
    end

    assign finish      = item.last_byte || item.empty_path;
    // Items that give no verdict never wait for the output register.
    assign advance     = item_valid && (!finish || out_space);
    assign result_load = advance && finish;

    always_comb
    begin
        upd = state_reg;
        if (state_reg.byte_count < COUNT_SAT)
        begin
            upd.byte_count = state_reg.byte_count + 11'd1;
        end

        unique case (mode_reg)
            MODE_UNUSED:
            begin
                upd.rejected = 1'b1;
            end
            MODE_LEAF:
            begin
                if (item.path_byte == CHAR_NUL || item.path_byte == CHAR_SLASH)
                begin
                    upd.rejected = 1'b1;
                end
                upd = add_byte(upd, item.path_byte);
            end
            MODE_RELATIVE, MODE_ABSOLUTE:
            begin
                if (mode_reg == MODE_ABSOLUTE && state_reg.byte_count == '0)
                begin
                    // The leading slash of a root path opens no component.
                    if (item.path_byte != CHAR_SLASH)
                    begin
                        upd.rejected = 1'b1;
                    end
                    upd.previous_was_slash = 1'b1;
                end
                else if (item.path_byte == CHAR_SLASH)
                begin
                    upd = close_component(upd, MaxCompBytes, MaxComps);
                    upd.previous_was_slash = 1'b1;
                end
                else
                begin
                    if (item.path_byte == CHAR_NUL || item.path_byte >= CHAR_HIGH ||
                        item.path_byte == CHAR_BACKSLASH)
                    begin
                        upd.rejected = 1'b1;
                    end
                    upd = add_byte(upd, item.path_byte);
                end
            end
            default:
            begin
                upd.rejected = 1'b1;
            end
        endcase

        if (item.last_byte)
        begin
            unique case (mode_reg)
                MODE_LEAF:
                begin
                    if (upd.byte_count > MaxLeaf || is_dot(upd.dot_pattern))
                    begin
                        upd.rejected = 1'b1;
                    end
                end
                MODE_RELATIVE, MODE_ABSOLUTE:
                begin
                    if (upd.byte_count > MaxPath)
                    begin
                        upd.rejected = 1'b1;
                    end
                    if (mode_reg == MODE_ABSOLUTE && upd.byte_count < 11'd2)
                    begin
                        upd.rejected = 1'b1;
                    end
                    // A trailing slash fails; otherwise the open component closes.
                    if (upd.previous_was_slash)
                    begin
                        upd.rejected = 1'b1;
                    end
                    else
                    begin
                        upd = close_component(upd, MaxCompBytes, MaxComps);
                    end
                end
                default:
                begin
                    upd.rejected = upd.rejected;
                end
            endcase
        end
    end

    always_comb
    begin
        if (item.empty_path)
        begin
            result.path_safe   = 1'b0;
            result.path_length = state_reg.byte_count;
        end
        else
        begin
            result.path_safe   = !upd.rejected;
            result.path_length = upd.byte_count;
        end
        state_next = finish ? STATE_CLEAR : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: rtl/plsc_out_stage.sv
// ----------------------------------------------------------------------------
// plsc_out_stage
// Result register that holds a verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module plsc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  plsc_pkg::result_t result,
    output logic              space,
    plsc_out_if.source        verdict
);
    import plsc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space      = !valid_reg || verdict.ready;
    assign valid_next = load || (valid_reg && !verdict.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign verdict.valid       = valid_reg;
    assign verdict.path_safe   = result_reg.path_safe;
    assign verdict.path_length = result_reg.path_length;
endmodule

FILE: rtl/plsc_checker.sv
// ----------------------------------------------------------------------------
// plsc_checker
// Port-level checks of the path check block, bound to its top level.
// ----------------------------------------------------------------------------
module plsc_checker #(
    parameter int unsigned MAX_PATH_BYTES = 1024
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_safe,
    input logic [10:0] out_length
);
    import plsc_pkg::*;

    localparam logic [COUNT_W-1:0] MaxPath = COUNT_W'(MAX_PATH_BYTES);

    // A verdict held by the receiver keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_safe) && $stable(out_length))
    else $error("stalled verdict changed");

    // A safe path has at least one byte and fits the length limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_safe |-> out_length != 11'd0 && out_length <= MaxPath)
    else $error("safe verdict with bad length");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_length <= COUNT_SAT)
    else $error("path length above saturation");

    // A verdict into an empty result register comes from an item that passed through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("verdict without a matching item");

    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
    else $error("verdict during reset");
endmodule

bind path_lexical_safety_check plsc_checker #(
    .MAX_PATH_BYTES (MAX_PATH_BYTES)
) u_plsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (bytes.valid),
    .in_ready   (bytes.ready),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .out_safe   (verdict.path_safe),
    .out_length (verdict.path_length)
);
